// ===== src/bpc_pkg.sv =====
// Shared widths, register indexes, calibration record and constants for the compensation block.
package bpc_pkg;

  localparam int RAW_W    = 24;
  localparam int CAL_W    = 16;
  localparam int TEMP_W   = 16;
  localparam int PRES_W   = 18;
  localparam int REG_IDX_W = 3;
  localparam int STAGES   = 10;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PRESSURE_SENS   = 3'd0,
    REG_PRESSURE_OFFSET = 3'd1,
    REG_SENS_TEMPCO     = 3'd2,
    REG_OFFSET_TEMPCO   = 3'd3,
    REG_REF_TEMP        = 3'd4,
    REG_TEMP_SENS       = 3'd5,
    REG_SECOND_ORDER    = 3'd6
  } bpc_reg_idx_t;

  typedef struct packed {
    logic [CAL_W-1:0] pressure_sens;
    logic [CAL_W-1:0] pressure_offset;
    logic [CAL_W-1:0] sens_tempco;
    logic [CAL_W-1:0] offset_tempco;
    logic [CAL_W-1:0] ref_temp;
    logic [CAL_W-1:0] temp_sens;
    logic             second_order_enable;
  } bpc_cal_t;

  localparam bpc_cal_t CAL_RESET = '{
    pressure_sens:       16'd0,
    pressure_offset:     16'd0,
    sens_tempco:         16'd0,
    offset_tempco:       16'd0,
    ref_temp:            16'd0,
    temp_sens:           16'd0,
    second_order_enable: 1'b1
  };

  // 20.00 C in centidegrees, and the distance from there down to -15.00 C
  localparam logic signed [19:0] TEMP_BASE   = 20'sd2000;
  localparam logic signed [18:0] COLD_OFFSET = 19'sd3500;
  localparam logic signed [18:0] COLD_LIMIT  = -19'sd3500;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7FFF;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;
  localparam logic [PRES_W-1:0]        PRES_MAX = 18'h3FFFF;

endpackage

// ===== src/bpc_if.sv =====
// Handshake channels of the compensation block: readings in, results out, calibration writes.
interface bpc_in_if;
  logic                       valid;
  logic                       ready;
  logic [bpc_pkg::RAW_W-1:0]  pres_reading;
  logic [bpc_pkg::RAW_W-1:0]  raw_temp;

  modport source (output valid, pres_reading, raw_temp, input ready);
  modport sink   (input valid, pres_reading, raw_temp, output ready);
endinterface

interface bpc_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [bpc_pkg::TEMP_W-1:0] temp_centideg;
  logic [bpc_pkg::PRES_W-1:0]        pressure_centimbar;

  modport source (output valid, temp_centideg, pressure_centimbar, input ready);
  modport sink   (input valid, temp_centideg, pressure_centimbar, output ready);
endinterface

interface bpc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bpc_pkg::REG_IDX_W-1:0] index;
  logic [bpc_pkg::CAL_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/baro_pressure_temp_compensation.sv =====
// Top level: ten-stage pipeline computing compensated temperature and pressure.
//
// Each transfer on in_chan carries one raw pressure and one raw temperature reading;
// exactly one result follows on out_chan, in order, after passing every stage. A new
// pair is taken every cycle unless all stages are full and the output is stalled: the
// ten register stages (difference, three coefficient multiplies, first-order sums,
// squares, constant scaling, correction sums, subtraction, the split 24 x 40 pressure
// multiply, its recombination and the final shift and clamp) each hold one item, and
// a stage advances whenever the one after it is empty or moving on, so bubbles close
// up and inputs are still taken while a finished result waits. Calibration words are
// written on cfg_chan, which is always ready; write them only while no item is in
// flight. Temperature is in hundredths of a degree, clamped to the signed 16-bit
// range; pressure is in hundredths of a millibar, clamped to 0 .. 262143. Right
// shifts floor.
module baro_pressure_temp_compensation (
  input  logic        clk,
  input  logic        rst_n,
  bpc_in_if.sink      in_chan,
  bpc_out_if.source   out_chan,
  bpc_cfg_if.sink     cfg_chan
);

  localparam int NS = bpc_pkg::STAGES;

  bpc_pkg::bpc_cal_t cal;

  // Calibration writes are always taken
  assign cfg_chan.ready = 1'b1;

  bpc_cal_regs u_cal_regs (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_chan.valid),
    .wr_index (cfg_chan.index),
    .wr_data  (cfg_chan.data),
    .cal      (cal)
  );

  // ------------------------------------------------------------------
  // Stage control: a stage advances when it is empty or its successor advances
  // ------------------------------------------------------------------
  logic [NS-1:0] valid_r;
  logic [NS-1:0] valid_nxt;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !valid_r[NS-1] || out_chan.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  always_comb begin
    valid_nxt[0] = adv[0] ? in_chan.valid : valid_r[0];
    for (int k = 1; k < NS; k++) begin
      valid_nxt[k] = adv[k] ? valid_r[k-1] : valid_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign in_chan.ready = adv[0];

  // ------------------------------------------------------------------
  // Stage 0: temperature difference against the reference (dT)
  // ------------------------------------------------------------------
  logic [23:0]        s0_d1_r;
  logic signed [24:0] s0_dt_r;
  logic signed [24:0] s0_dt_nxt;

  assign s0_dt_nxt = $signed({1'b0, in_chan.raw_temp}) - $signed({1'b0, cal.ref_temp, 8'd0});

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s0_d1_r <= in_chan.pres_reading;
      s0_dt_r <= s0_dt_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: coefficient products and dT squared
  // ------------------------------------------------------------------
  logic [23:0]        s1_d1_r;
  logic signed [41:0] s1_p6_r, s1_p6_nxt;
  logic signed [41:0] s1_p4_r, s1_p4_nxt;
  logic signed [41:0] s1_p3_r, s1_p3_nxt;
  logic signed [49:0] s1_pdd_r, s1_pdd_nxt;

  assign s1_p6_nxt  = s0_dt_r * $signed({1'b0, cal.temp_sens});
  assign s1_p4_nxt  = s0_dt_r * $signed({1'b0, cal.offset_tempco});
  assign s1_p3_nxt  = s0_dt_r * $signed({1'b0, cal.sens_tempco});
  assign s1_pdd_nxt = s0_dt_r * s0_dt_r;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_d1_r  <= s0_d1_r;
      s1_p6_r  <= s1_p6_nxt;
      s1_p4_r  <= s1_p4_nxt;
      s1_p3_r  <= s1_p3_nxt;
      s1_pdd_r <= s1_pdd_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Stage 2: first-order TEMP, OFF, SENS; T2; low-temperature decisions
  // ------------------------------------------------------------------
  logic [23:0]        s2_d1_r;
  logic signed [18:0] s2_a_nxt, s2_a_r;       // TEMP - 2000
  logic signed [18:0] s2_b_nxt, s2_b_r;       // TEMP + 1500
  logic signed [19:0] s2_temp1_nxt, s2_temp1_r;
  logic signed [39:0] s2_off1_nxt, s2_off1_r;
  logic signed [39:0] s2_sens1_nxt, s2_sens1_r;
  logic [17:0]        s2_t2_nxt, s2_t2_r;
  logic               s2_warm_nxt, s2_warm_r;  // second order applies
  logic               s2_cold_nxt, s2_cold_r;  // extra term below -15.00 C

  assign s2_a_nxt     = s1_p6_r[41:23];
  assign s2_b_nxt     = s2_a_nxt + bpc_pkg::COLD_OFFSET;
  assign s2_temp1_nxt = {s2_a_nxt[18], s2_a_nxt} + bpc_pkg::TEMP_BASE;
  assign s2_off1_nxt  = $signed({8'd0, cal.pressure_offset, 16'd0})
                      + $signed({{5{s1_p4_r[41]}}, s1_p4_r[41:7]});
  assign s2_sens1_nxt = $signed({9'd0, cal.pressure_sens, 15'd0})
                      + $signed({{6{s1_p3_r[41]}}, s1_p3_r[41:8]});
  assign s2_t2_nxt    = s1_pdd_r[48:31];
  assign s2_warm_nxt  = cal.second_order_enable && s2_a_nxt[18];
  assign s2_cold_nxt  = s2_a_nxt < bpc_pkg::COLD_LIMIT;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_d1_r    <= s1_d1_r;
      s2_a_r     <= s2_a_nxt;
      s2_b_r     <= s2_b_nxt;
      s2_temp1_r <= s2_temp1_nxt;
      s2_off1_r  <= s2_off1_nxt;
      s2_sens1_r <= s2_sens1_nxt;
      s2_t2_r    <= s2_t2_nxt;
      s2_warm_r  <= s2_warm_nxt;
      s2_cold_r  <= s2_cold_nxt;
    end
  end

  // ------------------------------------------------------------------
  // Stage 3: squares of the temperature deviations; final TEMP
  // ------------------------------------------------------------------
  logic [23:0]        s3_d1_r;
  logic signed [37:0] s3_sq_nxt, s3_sq_r;
  logic signed [37:0] s3_sq2_nxt, s3_sq2_r;
  logic signed [19:0] s3_temp2_nxt, s3_temp2_r;
  logic signed [39:0] s3_off1_r;
  logic signed [39:0] s3_sens1_r;
  logic               s3_warm_r;
  logic               s3_cold_r;

  assign s3_sq_nxt    = s2_a_r * s2_a_r;
  assign s3_sq2_nxt   = s2_b_r * s2_b_r;
  assign s3_temp2_nxt = s2_warm_r ? (s2_temp1_r - $signed({2'b00, s2_t2_r})) : s2_temp1_r;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_d1_r    <= s2_d1_r;
      s3_sq_r    <= s3_sq_nxt;
      s3_sq2_r   <= s3_sq2_nxt;
      s3_temp2_r <= s3_temp2_nxt;
      s3_off1_r  <= s2_off1_r;
      s3_sens1_r <= s2_sens1_r;
      s3_warm_r  <= s2_warm_r;
      s3_cold_r  <= s2_cold_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 4: constant scaling (5 sq, 7 sq2, 11 sq2), zeroed where unused
  // ------------------------------------------------------------------
  logic [23:0]        s4_d1_r;
  logic [39:0]        s4_sq_w, s4_sq2_w;
  logic [39:0]        s4_sq5_nxt, s4_sq5_r;
  logic [39:0]        s4_x7_nxt, s4_x7_r;
  logic [39:0]        s4_x11_nxt, s4_x11_r;
  logic signed [19:0] s4_temp2_r;
  logic signed [39:0] s4_off1_r;
  logic signed [39:0] s4_sens1_r;

  assign s4_sq_w  = {2'b00, s3_sq_r};
  assign s4_sq2_w = {2'b00, s3_sq2_r};

  always_comb begin
    s4_sq5_nxt = '0;
    s4_x7_nxt  = '0;
    s4_x11_nxt = '0;
    if (s3_warm_r) begin
      s4_sq5_nxt = {s4_sq_w[37:0], 2'b00} + s4_sq_w;
      if (s3_cold_r) begin
        s4_x7_nxt  = {s4_sq2_w[36:0], 3'b000} - s4_sq2_w;
        s4_x11_nxt = {s4_sq2_w[36:0], 3'b000} + {s4_sq2_w[38:0], 1'b0} + s4_sq2_w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_d1_r    <= s3_d1_r;
      s4_sq5_r   <= s4_sq5_nxt;
      s4_x7_r    <= s4_x7_nxt;
      s4_x11_r   <= s4_x11_nxt;
      s4_temp2_r <= s3_temp2_r;
      s4_off1_r  <= s3_off1_r;
      s4_sens1_r <= s3_sens1_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 5: OFF2 and SENS2, each part floored on its own
  // ------------------------------------------------------------------
  logic [23:0]        s5_d1_r;
  logic [39:0]        s5_off2_nxt, s5_off2_r;
  logic [39:0]        s5_sens2_nxt, s5_sens2_r;
  logic signed [19:0] s5_temp2_r;
  logic signed [39:0] s5_off1_r;
  logic signed [39:0] s5_sens1_r;

  assign s5_off2_nxt  = (s4_sq5_r >> 1) + s4_x7_r;
  assign s5_sens2_nxt = (s4_sq5_r >> 2) + (s4_x11_r >> 1);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_d1_r    <= s4_d1_r;
      s5_off2_r  <= s5_off2_nxt;
      s5_sens2_r <= s5_sens2_nxt;
      s5_temp2_r <= s4_temp2_r;
      s5_off1_r  <= s4_off1_r;
      s5_sens1_r <= s4_sens1_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 6: corrected OFF and SENS
  // ------------------------------------------------------------------
  logic [23:0]        s6_d1_r;
  logic signed [39:0] s6_off_nxt, s6_off_r;
  logic signed [39:0] s6_sens_nxt, s6_sens_r;
  logic signed [19:0] s6_temp2_r;

  assign s6_off_nxt  = s5_off1_r - $signed(s5_off2_r);
  assign s6_sens_nxt = s5_sens1_r - $signed(s5_sens2_r);

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_d1_r    <= s5_d1_r;
      s6_off_r   <= s6_off_nxt;
      s6_sens_r  <= s6_sens_nxt;
      s6_temp2_r <= s5_temp2_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 7: D1 * SENS as two 24 x 20 partial products
  // ------------------------------------------------------------------
  logic signed [44:0] s7_pm_hi_nxt, s7_pm_hi_r;
  logic [43:0]        s7_pm_lo_nxt, s7_pm_lo_r;
  logic signed [39:0] s7_off_r;
  logic signed [19:0] s7_temp2_r;

  assign s7_pm_hi_nxt = $signed({1'b0, s6_d1_r}) * $signed(s6_sens_r[39:20]);
  assign s7_pm_lo_nxt = s6_d1_r * s6_sens_r[19:0];

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_pm_hi_r <= s7_pm_hi_nxt;
      s7_pm_lo_r <= s7_pm_lo_nxt;
      s7_off_r   <= s6_off_r;
      s7_temp2_r <= s6_temp2_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 8: recombine the partial products (the full product fits 64 bits)
  // ------------------------------------------------------------------
  logic signed [63:0] s8_prod_nxt, s8_prod_r;
  logic signed [39:0] s8_off_r;
  logic signed [19:0] s8_temp2_r;

  assign s8_prod_nxt = $signed({s7_pm_hi_r[43:0], 20'd0}) + $signed({20'd0, s7_pm_lo_r});

  always_ff @(posedge clk) begin
    if (adv[8]) begin
      s8_prod_r  <= s8_prod_nxt;
      s8_off_r   <= s7_off_r;
      s8_temp2_r <= s7_temp2_r;
    end
  end

  // ------------------------------------------------------------------
  // Stage 9: pressure shift, clamp both results, hold for the output transfer
  // ------------------------------------------------------------------
  logic signed [43:0]                s9_x;
  logic signed [bpc_pkg::TEMP_W-1:0] s9_temp_nxt, s9_temp_r;
  logic [bpc_pkg::PRES_W-1:0]        s9_pres_nxt, s9_pres_r;

  assign s9_x = $signed({s8_prod_r[63], s8_prod_r[63:21]})
              - $signed({{4{s8_off_r[39]}}, s8_off_r});

  always_comb begin
    if (s9_x[43]) begin
      s9_pres_nxt = '0;
    end else if (|s9_x[42:33]) begin
      s9_pres_nxt = bpc_pkg::PRES_MAX;
    end else begin
      s9_pres_nxt = s9_x[32:15];
    end
  end

  always_comb begin
    if (s8_temp2_r[19:15] == 5'b00000 || s8_temp2_r[19:15] == 5'b11111) begin
      s9_temp_nxt = s8_temp2_r[15:0];
    end else if (s8_temp2_r[19]) begin
      s9_temp_nxt = bpc_pkg::TEMP_MIN;
    end else begin
      s9_temp_nxt = bpc_pkg::TEMP_MAX;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[9]) begin
      s9_temp_r <= s9_temp_nxt;
      s9_pres_r <= s9_pres_nxt;
    end
  end

  assign out_chan.valid              = valid_r[NS-1];
  assign out_chan.temp_centideg      = s9_temp_r;
  assign out_chan.pressure_centimbar = s9_pres_r;

  // ------------------------------------------------------------------
  // Checks
  // ------------------------------------------------------------------

  // Input is held off only when every stage is full and the output is stalled
  a_backpressure_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (out_chan.valid && !out_chan.ready && (&valid_r)))
    else $error("input stalled while the pipeline has room");

  // An accepted pair always lands in the first stage
  a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_chan.valid && in_chan.ready) |=> valid_r[0])
    else $error("accepted transfer lost at pipeline entry");

  // The enable register follows a write to its index
  a_enable_write: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_chan.valid && cfg_chan.ready && cfg_chan.index == bpc_pkg::REG_SECOND_ORDER)
      |=> (cal.second_order_enable == $past(cfg_chan.data[0])))
    else $error("second-order enable not updated by its write");

endmodule

// ===== src/bpc_cal_regs.sv =====
// Calibration register file: decodes index writes into the calibration record.
module bpc_cal_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [bpc_pkg::REG_IDX_W-1:0] wr_index,
  input  logic [bpc_pkg::CAL_W-1:0]     wr_data,
  output bpc_pkg::bpc_cal_t             cal
);

  bpc_pkg::bpc_cal_t cal_r;
  bpc_pkg::bpc_cal_t cal_nxt;

  always_comb begin
    cal_nxt = cal_r;
    if (wr_en) begin
      case (wr_index)
        bpc_pkg::REG_PRESSURE_SENS:   cal_nxt.pressure_sens   = wr_data;
        bpc_pkg::REG_PRESSURE_OFFSET: cal_nxt.pressure_offset = wr_data;
        bpc_pkg::REG_SENS_TEMPCO:     cal_nxt.sens_tempco     = wr_data;
        bpc_pkg::REG_OFFSET_TEMPCO:   cal_nxt.offset_tempco   = wr_data;
        bpc_pkg::REG_REF_TEMP:        cal_nxt.ref_temp        = wr_data;
        bpc_pkg::REG_TEMP_SENS:       cal_nxt.temp_sens       = wr_data;
        bpc_pkg::REG_SECOND_ORDER:    cal_nxt.second_order_enable = wr_data[0];
        default:                      cal_nxt = cal_r; // drop writes beyond the list
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= bpc_pkg::CAL_RESET;
    end else begin
      cal_r <= cal_nxt;
    end
  end

  assign cal = cal_r;

endmodule
